// ----- design/sshl_pkg.sv -----
// Package for the Shamir share evaluator (Horner's rule modulo the Ed25519 order L).
// Holds the bus widths and the group order; used by the top level and its checker.
package sshl_pkg;

   localparam int POINT_W     = 8;
   localparam int COEF_W      = 253;
   localparam int REQ_TDATA_W = 264;
   localparam int RSP_TDATA_W = 256;
   localparam int HORNER_W    = 262;
   localparam int QUOT_W      = 10;

   // L = 2^252 + 27742317777372353535851937790883648493
   localparam logic [RSP_TDATA_W-1:0] ORD_L =
      256'h1000000000000000000000000000000014def9dea2f79cd65812631a5cf5d3ed;

endpackage

// ----- design/shamir_share_horner_mod_l.sv -----
// Top level of the Shamir share evaluator: Horner step and reduction modulo L.
// Depends on sshl_pkg for widths and the group order.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-----------------------------------------
//   req     | in  | req_tvalid / req_tready   | req_tdata: point, coefficient; req_tlast
//   rsp     | out | rsp_tvalid / rsp_tready   | rsp_tdata: share modulo L
//
// One coefficient beat per cycle unless a last beat waits on a stalled result; the
// accumulator loop (multiply by the point, add, reduce modulo L) is combinational around acc_ff.
// A share moves from the input stage into the result register and is offered from there.
// Reset clears the input stage, the result register and arms the next polynomial.
// A stalled result holds only beats that end a polynomial; other beats still flow.
module shamir_share_horner_mod_l (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] eval_point, [71:8] coef_w0, [135:72] coef_w1, [199:136] coef_w2,
   // [260:200] coef_w3, [263:261] zero
   input  logic [sshl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [63:0] share_w0, [127:64] share_w1, [191:128] share_w2, [252:192] share_w3,
   // [255:253] zero
   output logic [sshl_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   logic                              s1_valid_ff, s1_valid_in;
   logic [sshl_pkg::POINT_W-1:0]      s1_point_ff;
   logic [sshl_pkg::COEF_W-1:0]       s1_coef_ff;
   logic                              s1_last_ff;
   logic [sshl_pkg::COEF_W-1:0]       acc_ff, acc_in;
   logic                              first_ff, first_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sshl_pkg::COEF_W-1:0]       share_ff, share_in;

   logic                              out_free;
   logic                              advance;
   logic                              req_take;
   logic [sshl_pkg::COEF_W+sshl_pkg::POINT_W-1:0] product;
   logic [sshl_pkg::HORNER_W-1:0]     horner;
   logic [sshl_pkg::QUOT_W-1:0]       quot;
   logic [sshl_pkg::HORNER_W:0]       quot_l;
   logic [sshl_pkg::HORNER_W+1:0]     diff;
   logic [sshl_pkg::RSP_TDATA_W-1:0]  reduced;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // acc * x + coef (coef alone on a first beat), then subtract the quotient estimate times L and fix up once
   assign product = (sshl_pkg::COEF_W+sshl_pkg::POINT_W)'(acc_ff)
                  * (sshl_pkg::COEF_W+sshl_pkg::POINT_W)'(s1_point_ff);
   assign horner  = first_ff ? sshl_pkg::HORNER_W'(s1_coef_ff)
                             : sshl_pkg::HORNER_W'(product) + sshl_pkg::HORNER_W'(s1_coef_ff);
   assign quot    = horner[sshl_pkg::HORNER_W-1:sshl_pkg::HORNER_W-sshl_pkg::QUOT_W];
   assign quot_l  = (sshl_pkg::HORNER_W+1)'(quot)
                  * (sshl_pkg::HORNER_W+1)'(sshl_pkg::ORD_L[sshl_pkg::COEF_W-1:0]);
   assign diff    = (sshl_pkg::HORNER_W+2)'(horner) - (sshl_pkg::HORNER_W+2)'(quot_l);
   assign reduced = diff[sshl_pkg::RSP_TDATA_W-1:0]
                  + (diff[sshl_pkg::HORNER_W+1] ? sshl_pkg::ORD_L
                                                : {sshl_pkg::RSP_TDATA_W{1'b0}});

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      acc_in       = acc_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      share_in     = share_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
         if (s1_last_ff) begin
            first_in     = 1'b1;
            rsp_valid_in = 1'b1;
            share_in     = reduced[sshl_pkg::COEF_W-1:0];
         end else begin
            first_in = 1'b0;
            acc_in   = reduced[sshl_pkg::COEF_W-1:0];
         end
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      share_ff <= share_in;
      if (req_take) begin
         s1_point_ff <= req_tdata[sshl_pkg::POINT_W-1:0];
         s1_coef_ff  <= req_tdata[sshl_pkg::POINT_W+sshl_pkg::COEF_W-1:sshl_pkg::POINT_W];
         s1_last_ff  <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sshl_pkg::RSP_TDATA_W'(share_ff);

endmodule

// ----- design/sshl_checker.sv -----
// Port-level checker for the Shamir share evaluator, bound to the top level.
// Depends on sshl_pkg for widths and the group order.
module sshl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [sshl_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [sshl_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tlast))
      else $error("coefficient beat changed while stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_share_below_l: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata < sshl_pkg::ORD_L)
      else $error("share not reduced below L");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with the result register empty");

   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat offered straight after reset");

endmodule

bind shamir_share_horner_mod_l sshl_checker u_sshl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/tb.sv -----
// Testbench for shamir_share_horner_mod_l: drives coefficient beats, evaluates each
// polynomial by Horner's rule modulo L on its own side and checks every share beat.
// Depends on sshl_pkg for the bus widths and the group order.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POINT_W     = sshl_pkg::POINT_W;
   localparam int COEF_W      = sshl_pkg::COEF_W;
   localparam int REQ_TDATA_W = sshl_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = sshl_pkg::RSP_TDATA_W;
   localparam int HORNER_W    = sshl_pkg::HORNER_W;
   localparam int QUOT_W      = sshl_pkg::QUOT_W;
   localparam logic [RSP_TDATA_W-1:0] ORD_L = sshl_pkg::ORD_L;

   localparam logic [COEF_W-1:0] ORDER       = ORD_L[COEF_W-1:0];
   localparam logic [COEF_W-1:0] ALL_ONES    = '1;
   localparam int                RANDOM_BEATS = 1900;
   localparam int                CALM_AFTER   = 1700;
   localparam int                CYCLE_LIMIT  = 200000;

   typedef struct {
      logic [POINT_W-1:0] point;
      logic [COEF_W-1:0]  coef;
      logic               last;
      logic               typed;
      logic [COEF_W-1:0]  share;
   } coef_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic [COEF_W-1:0] share_queue[$];
   coef_row_type      directed_rows[$];
   logic [COEF_W-1:0] horner_acc = '0;
   logic              horner_first = 1'b1;
   logic              calm = 1'b0;
   int                mismatches = 0;
   int                cycles = 0;
   int                stall_left = 0;

   shamir_share_horner_mod_l dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [COEF_W-1:0] reduce_mod_l(input logic [HORNER_W-1:0] t);
      logic [QUOT_W-1:0] q;
      logic [263:0]      d;
      q = t[HORNER_W-1:252];
      d = {2'b00, t} - 264'(q) * {8'h00, ORD_L};
      if (d[263]) begin
         d = d + {8'h00, ORD_L};
      end
      return d[COEF_W-1:0];
   endfunction

   function automatic logic [COEF_W-1:0] horner_step(input logic [COEF_W-1:0] acc,
                                                     input logic [POINT_W-1:0] x,
                                                     input logic [COEF_W-1:0] coef,
                                                     input logic first);
      logic [HORNER_W-1:0] t;
      if (first) begin
         t = {{(HORNER_W-COEF_W){1'b0}}, coef};
      end else begin
         t = HORNER_W'(acc) * HORNER_W'(x) + HORNER_W'(coef);
      end
      return reduce_mod_l(t);
   endfunction

   function automatic logic [63:0] share_word(input logic [COEF_W-1:0] s, input int w);
      if (w < 3) begin
         return s[64*w +: 64];
      end
      return {3'b000, s[252:192]};
   endfunction

   function automatic logic [COEF_W-1:0] pick_coef();
      logic [255:0] w;
      logic [COEF_W-1:0] c;
      int sel;
      for (int i = 0; i < 8; i++) begin
         w[32*i +: 32] = $urandom;
      end
      sel = $urandom_range(0, 19);
      case (sel)
         0: begin
            c = '0;
         end
         1: begin
            c = ORDER - 1;
         end
         2: begin
            c = ALL_ONES;
         end
         3: begin
            c = ORDER + COEF_W'(w[15:0]);
         end
         4: begin
            c = ORDER - 1 - COEF_W'(w[15:0]);
         end
         5, 6, 7, 8: begin
            c = w[COEF_W-1:0];
         end
         default: begin
            c = {1'b0, w[251:0]};
         end
      endcase
      return c;
   endfunction

   function automatic logic [POINT_W-1:0] pick_point();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
         return '0;
      end
      if (sel == 1) begin
         return '1;
      end
      return POINT_W'($urandom_range(1, 255));
   endfunction

   task automatic add_row(input logic [POINT_W-1:0] point, input logic [COEF_W-1:0] coef,
                          input logic last, input logic typed,
                          input logic [COEF_W-1:0] share);
      coef_row_type r;
      r.point = point;
      r.coef  = coef;
      r.last  = last;
      r.typed = typed;
      r.share = share;
      directed_rows.push_back(r);
   endtask

   task automatic send_coef(input coef_row_type r);
      logic [COEF_W-1:0] nxt;
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, r.coef, r.point};
      req_tlast  <= r.last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      nxt = horner_step(horner_acc, r.point, r.coef, horner_first);
      if (r.last) begin
         share_queue.push_back(r.typed ? r.share : nxt);
         horner_acc   = '0;
         horner_first = 1'b1;
      end else begin
         horner_acc   = nxt;
         horner_first = 1'b0;
      end
   endtask

   // result side: random stall bursts (always ready once calm), compare each share beat
   always @(posedge clock) begin
      logic [COEF_W-1:0] want;
      cycles <= cycles + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (calm) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left <= stall_left - 1;
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left <= $urandom_range(0, 4);
         end else begin
            rsp_tready <= 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (share_queue.size() == 0) begin
               $display("%0t unexpected share beat %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = share_queue.pop_front();
               for (int w = 0; w < 4; w++) begin
                  if (share_word(rsp_tdata[COEF_W-1:0], w) != share_word(want, w)) begin
                     $display("%0t share_w%0d expected %h actual %h", $time, w,
                              share_word(want, w), share_word(rsp_tdata[COEF_W-1:0], w));
                     mismatches++;
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   initial begin
      coef_row_type r;
      int sent;
      int degree;
      logic [POINT_W-1:0] x;

      add_row(8'd1,   '0,             1'b1, 1'b1, '0);
      add_row(8'd1,   253'd1,         1'b1, 1'b1, 253'd1);
      add_row(8'd1,   ORDER - 1,      1'b1, 1'b1, ORDER - 1);
      add_row(8'd1,   ORDER,          1'b1, 1'b1, '0);
      add_row(8'd1,   ORDER + 5,      1'b1, 1'b1, 253'd5);
      add_row(8'd255, ALL_ONES,       1'b1, 1'b0, '0);
      add_row(8'd255, ORDER - 1,      1'b0, 1'b0, '0);
      add_row(8'd255, ORDER - 1,      1'b0, 1'b0, '0);
      add_row(8'd255, ORDER - 1,      1'b1, 1'b0, '0);
      add_row(8'd0,   253'd7,         1'b0, 1'b0, '0);
      add_row(8'd0,   253'd9,         1'b1, 1'b1, 253'd9);
      add_row(8'd1,   253'd1,         1'b0, 1'b0, '0);
      add_row(8'd1,   253'd2,         1'b0, 1'b0, '0);
      add_row(8'd1,   253'd3,         1'b1, 1'b1, 253'd6);
      add_row(8'd2,   253'd1 << 252,  1'b0, 1'b0, '0);
      add_row(8'd2,   ALL_ONES,       1'b1, 1'b0, '0);
      add_row(8'd255, ALL_ONES,       1'b0, 1'b0, '0);
      add_row(8'd255, ALL_ONES,       1'b0, 1'b0, '0);
      add_row(8'd255, ALL_ONES,       1'b1, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_coef(directed_rows[i]);
      end

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         degree = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 6);
         x = pick_point();
         for (int k = 0; k <= degree; k++) begin
            r.point = ($urandom_range(0, 19) == 0) ? pick_point() : x;
            r.coef  = pick_coef();
            r.last  = (k == degree);
            r.typed = 1'b0;
            r.share = '0;
            calm = (sent >= CALM_AFTER);
            send_coef(r);
            sent++;
         end
      end

      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (share_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/sshl_pkg.sv
design/shamir_share_horner_mod_l.sv
design/sshl_checker.sv
sim/tb.sv
